@@ hdl/lap_pkg.sv @@
// Shared types, register codes and mask coefficients for the 3x3 Laplacian filter.
// No dependencies; every other file of the filter but lap_ram uses this package.
package lap_pkg;

    // Field and register widths that do not vary with the parameters.
    localparam int MASK_SEL_BITS   = 3;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int MAG_BITS        = 11;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    // Reset values of the configuration registers.
    localparam logic [MASK_SEL_BITS-1:0]   MASK_SEL_RESET     = '0;
    localparam logic [WIDTH_REG_BITS-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd4096;

    // Output queue sizing.
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int FIFO_AW        = $clog2(OUT_FIFO_DEPTH);
    localparam int FIFO_CW        = $clog2(OUT_FIFO_DEPTH + 1);

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_MASK_SELECT  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_reg_idx_e;

    // Mask codes.
    typedef enum logic [MASK_SEL_BITS-1:0] {
        MASK_LAP4   = 3'd0,
        MASK_LAP8   = 3'd1,
        MASK_NEG4   = 3'd2,
        MASK_NEG8   = 3'd3,
        MASK_SHARP4 = 3'd4,
        MASK_SHARP8 = 3'd5
    } t_mask_e;

    typedef struct packed {
        logic [MASK_SEL_BITS-1:0]   mask_select;
        logic [WIDTH_REG_BITS-1:0]  image_width;
        logic [HEIGHT_REG_BITS-1:0] image_height;
    } t_cfg;

    // Per-item control that travels alongside the pixel data.
    typedef struct packed {
        logic valid;
        logic produce;
        logic frame_end;
    } t_tag;

    // Every mask has the neighbors weighted opposite in sign to the center,
    // so the magnitude is |gain * center - neighbor sum|.
    typedef struct packed {
        logic [3:0] center_gain;
        logic       use_corner;
    } t_coef;

    function automatic t_coef mask_coef(input logic [MASK_SEL_BITS-1:0] sel);
        t_coef coef;
        unique case (sel) inside
            MASK_LAP8, MASK_NEG8: begin
                coef.center_gain = 4'd8;
                coef.use_corner  = 1'b1;
            end
            MASK_SHARP4: begin
                coef.center_gain = 4'd5;
                coef.use_corner  = 1'b0;
            end
            MASK_SHARP8: begin
                coef.center_gain = 4'd5;
                coef.use_corner  = 1'b1;
            end
            default: begin
                // Four-neighbor masks, and the unused codes fall back to them.
                coef.center_gain = 4'd4;
                coef.use_corner  = 1'b0;
            end
        endcase
        return coef;
    endfunction

endpackage

@@ hdl/lap_if.sv @@
// Stream interfaces of the 3x3 Laplacian filter: pixel input and result output.
// Depends on lap_pkg for the result width.
interface lap_px_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lap_res_if;
    logic                         valid;
    logic                         ready;
    logic [lap_pkg::MAG_BITS-1:0] magnitude;
    logic                         frame_end;

    modport source (output valid, output magnitude, output frame_end, input ready);
    modport sink   (input valid, input magnitude, input frame_end, output ready);
endinterface

@@ hdl/lap_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module lap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/lap_cfg_regs.sv @@
// APB-style configuration registers of the 3x3 Laplacian filter.
// Depends on lap_pkg for register codes, widths and reset values.
module lap_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lap_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lap_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lap_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output lap_pkg::t_cfg                       o_cfg
);
    import lap_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_MASK_SELECT:  n_cfg.mask_select  = pwdata[MASK_SEL_BITS-1:0];
                REG_IMAGE_WIDTH:  n_cfg.image_width  = pwdata[WIDTH_REG_BITS-1:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = pwdata[HEIGHT_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_select  <= MASK_SEL_RESET;
            r_cfg.image_width  <= IMAGE_WIDTH_RESET;
            r_cfg.image_height <= IMAGE_HEIGHT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MASK_SELECT:  prdata = APB_DATA_BITS'(r_cfg.mask_select);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(r_cfg.image_height);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

@@ hdl/lap_line_buf.sv @@
// Line stores, raster counters and 3x3 window of the Laplacian filter.
// Depends on lap_pkg and instantiates lap_ram twice.
module lap_line_buf #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  lap_pkg::t_cfg         i_cfg,
    output logic [PIXEL_BITS-1:0] o_win [9],
    output lap_pkg::t_tag         o_tag,
    output logic [1:0]            o_pend
);
    import lap_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CMPC = ((CW > WIDTH_REG_BITS) ? CW : WIDTH_REG_BITS) + 1;
    localparam int CMPR = ((RW > HEIGHT_REG_BITS) ? RW : HEIGHT_REG_BITS) + 1;

    logic [CW-1:0]         r_col, n_col;
    logic [RW-1:0]         r_row, n_row;
    logic [CMPC-1:0]       w_eff, col_lim;
    logic [CMPR-1:0]       h_eff, row_lim;
    logic                  last_col, last_row;
    t_tag                  n_s1_tag;
    t_tag                  r_s1_tag, r_s2_tag;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [CW-1:0]         r_s1_addr;
    logic [PIXEL_BITS-1:0] up_rdata, mid_rdata;
    logic [PIXEL_BITS-1:0] r_win [9];

    // Clamp the frame size to the supported range and find the last column and row.
    always_comb begin
        if (CMPC'(i_cfg.image_width) < CMPC'(3)) begin
            w_eff = CMPC'(3);
        end else if (CMPC'(i_cfg.image_width) > CMPC'(MAX_WIDTH)) begin
            w_eff = CMPC'(MAX_WIDTH);
        end else begin
            w_eff = CMPC'(i_cfg.image_width);
        end
        if (CMPR'(i_cfg.image_height) < CMPR'(3)) begin
            h_eff = CMPR'(3);
        end else if (CMPR'(i_cfg.image_height) > CMPR'(MAX_HEIGHT)) begin
            h_eff = CMPR'(MAX_HEIGHT);
        end else begin
            h_eff = CMPR'(i_cfg.image_height);
        end
        col_lim  = w_eff - CMPC'(1);
        row_lim  = h_eff - CMPR'(1);
        last_col = CMPC'(r_col) >= col_lim;
        last_row = CMPR'(r_row) >= row_lim;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
        n_s1_tag.valid     = i_accept;
        n_s1_tag.produce   = (r_col >= CW'(2)) && (r_row >= RW'(2));
        n_s1_tag.frame_end = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_tag <= '0;
            r_s2_tag <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_s1_tag <= n_s1_tag;
            r_s2_tag <= r_s1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_px   <= i_pixel;
            r_s1_addr <= r_col;
        end
    end

    // Read on transfer, write back in the following cycle, when the read data is back.
    lap_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_tag.valid),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_rdata),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (up_rdata)
    );

    lap_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_ram_lower (
        .i_clk   (i_clk),
        .i_we    (r_s1_tag.valid),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_px),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (mid_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (r_s1_tag.valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3 + 0] <= r_win[k*3 + 1];
                r_win[k*3 + 1] <= r_win[k*3 + 2];
            end
            r_win[2] <= up_rdata;
            r_win[5] <= mid_rdata;
            r_win[8] <= r_s1_px;
        end
    end

    always_comb begin
        o_win = r_win;
    end

    assign o_tag  = r_s2_tag;
    assign o_pend = 2'(r_s1_tag.valid & r_s1_tag.produce)
                  + 2'(r_s2_tag.valid & r_s2_tag.produce);

    // A write-back never lands on the entry that the next transfer reads.
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_tag.valid && i_accept) |-> (r_s1_addr != r_col))
        else $error("line store read and write-back hit the same entry");

    // The column counter stays inside the line stores.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (CMPC'(r_col) < CMPC'(MAX_WIDTH)))
        else $error("column counter left the line store range");
endmodule

@@ hdl/lap_mask_mac.sv @@
// Mask arithmetic of the 3x3 Laplacian filter: neighbor sums, center gain, magnitude.
// Depends on lap_pkg for the mask coefficients and result width.
module lap_mask_mac #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [PIXEL_BITS-1:0]         i_win [9],
    input  lap_pkg::t_tag                 i_tag,
    input  logic [lap_pkg::MASK_SEL_BITS-1:0] i_mask_select,
    output lap_pkg::t_tag                 o_tag,
    output logic [lap_pkg::MAG_BITS-1:0]  o_magnitude,
    output logic [1:0]                    o_pend
);
    import lap_pkg::*;

    localparam int NW   = PIXEL_BITS + 3;
    localparam int PW   = PIXEL_BITS + 4;
    localparam int DW   = PIXEL_BITS + 5;
    localparam int MAGW = (DW > MAG_BITS) ? DW : MAG_BITS;

    t_coef          coef;
    logic [NW-1:0]  cross_sum, corner_sum, n_nsum, r_nsum;
    logic [PW-1:0]  n_prod, r_prod;
    t_tag           r_a_tag, r_out_tag;
    logic [DW-1:0]  diff, abs_diff;
    logic [MAGW-1:0] mag_ext;
    logic [MAG_BITS-1:0] r_mag;

    // First stage: neighbor sum and scaled center.
    always_comb begin
        coef       = mask_coef(i_mask_select);
        cross_sum  = NW'(i_win[1]) + NW'(i_win[3]) + NW'(i_win[5]) + NW'(i_win[7]);
        corner_sum = NW'(i_win[0]) + NW'(i_win[2]) + NW'(i_win[6]) + NW'(i_win[8]);
        n_nsum     = coef.use_corner ? cross_sum + corner_sum : cross_sum;
        n_prod     = PW'(i_win[4]) * PW'(coef.center_gain);
    end

    always_ff @(posedge i_clk) begin
        r_nsum <= n_nsum;
        r_prod <= n_prod;
    end

    // Second stage: difference and absolute value.
    always_comb begin
        diff     = DW'(r_prod) - DW'(r_nsum);
        abs_diff = diff[DW-1] ? (~diff + DW'(1)) : diff;
        mag_ext  = MAGW'(abs_diff);
    end

    always_ff @(posedge i_clk) begin
        r_mag <= mag_ext[MAG_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag   <= '0;
            r_out_tag <= '0;
        end else begin
            r_a_tag   <= i_tag;
            r_out_tag <= r_a_tag;
        end
    end

    assign o_tag       = r_out_tag;
    assign o_magnitude = r_mag;
    assign o_pend      = 2'(r_a_tag.valid & r_a_tag.produce)
                       + 2'(r_out_tag.valid & r_out_tag.produce);
endmodule

@@ hdl/lap_out_fifo.sv @@
// Output queue of the 3x3 Laplacian filter; drives the result channel.
// Depends on lap_pkg for the queue size and on lap_res_if.
module lap_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [lap_pkg::MAG_BITS-1:0]  i_magnitude,
    input  logic                          i_frame_end,
    lap_res_if.source                     o_res,
    output logic [lap_pkg::FIFO_CW-1:0]   o_count
);
    import lap_pkg::*;

    logic [MAG_BITS-1:0] r_mag_mem [OUT_FIFO_DEPTH];
    logic                r_end_mem [OUT_FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]  r_count;
    logic                rd;

    assign rd = o_res.valid & o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mag_mem[r_wr_ptr] <= i_magnitude;
            r_end_mem[r_wr_ptr] <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_wr, rd})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_res.valid     = (r_count != '0);
    assign o_res.magnitude = r_mag_mem[r_rd_ptr];
    assign o_res.frame_end = r_end_mem[r_rd_ptr];
    assign o_count         = r_count;
endmodule

@@ hdl/laplacian_3x3_sharpen_filter_unit.sv @@
// Top level of the 3x3 Laplacian filter over a raster pixel stream.
// Depends on lap_pkg, lap_if, lap_cfg_regs, lap_line_buf, lap_mask_mac and lap_out_fifo.
//
// The unit takes one grayscale pixel per clock in raster order and, for every
// interior pixel of the frame, delivers the absolute value of one of six fixed
// 3x3 Laplacian mask responses; border pixels give no result, and frame_end
// marks the result centered on the last interior pixel. Throughput is one pixel
// transfer per clock. The pixel that completes a window passes the line store
// read, the read-modify-write of the two line stores with the window shift,
// and the neighbor-sum and magnitude stages of the mask arithmetic before its
// result reaches the queue. The output queue holds eight results;
// pixel ready drops only when the queue plus the results still in the pipeline
// would fill it, so a stalled consumer throttles the input while a consumer that
// takes one result per clock never does. The two line stores are single memories
// of MAX_WIDTH entries, read and written back once per pixel; they need no
// clearing pass after reset, since every entry is written in the first two rows
// before any result depends on it. Mask select, width and height are set over
// the APB port at offsets 0x0, 0x4 and 0x8 and should only be changed while the
// unit is idle. Widths and heights outside the supported range act as the
// nearest supported value, and unused mask codes select the four-neighbor mask.
module laplacian_3x3_sharpen_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lap_px_if.sink                              i_px,
    lap_res_if.source                           o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lap_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lap_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lap_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import lap_pkg::*;

    t_cfg                  cfg;
    logic                  accept;
    logic [PIXEL_BITS-1:0] win [9];
    t_tag                  win_tag;
    t_tag                  res_tag;
    logic [MAG_BITS-1:0]   res_mag;
    logic [1:0]            lb_pend, mac_pend;
    logic [2:0]            pend;
    logic [FIFO_CW-1:0]    fifo_count;
    logic                  fifo_wr;

    // Registers.
    lap_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Credit check: accept only if every result in flight, plus this one,
    // is sure of a place in the output queue.
    assign pend        = 3'(lb_pend) + 3'(mac_pend);
    assign i_px.ready  = (FIFO_CW'(fifo_count) + FIFO_CW'(pend)) < FIFO_CW'(OUT_FIFO_DEPTH);
    assign accept      = i_px.valid & i_px.ready;

    lap_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (i_px.pixel),
        .i_cfg    (cfg),
        .o_win    (win),
        .o_tag    (win_tag),
        .o_pend   (lb_pend)
    );

    lap_mask_mac #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mask_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win         (win),
        .i_tag         (win_tag),
        .i_mask_select (cfg.mask_select),
        .o_tag         (res_tag),
        .o_magnitude   (res_mag),
        .o_pend        (mac_pend)
    );

    // Only interior pixels leave a result in the queue.
    assign fifo_wr = res_tag.valid & res_tag.produce;

    lap_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (fifo_wr),
        .i_magnitude (res_mag),
        .i_frame_end (res_tag.frame_end),
        .o_res       (o_res),
        .o_count     (fifo_count)
    );

    // Results in flight and queued never exceed the queue size.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FIFO_CW'(fifo_count) + FIFO_CW'(pend)) <= FIFO_CW'(OUT_FIFO_DEPTH))
        else $error("results in flight exceed output queue space");

    // A result never arrives at a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_wr |-> (fifo_count < FIFO_CW'(OUT_FIFO_DEPTH)))
        else $error("output queue overflow");
endmodule
